### hw/rtl/lats_pkg.sv
// Shared types, codes and constants for the toroidal life engine.
package lats_pkg;

   // Defaults for the grid storage bounds
   localparam int DEF_MAX_WIDTH  = 64;
   localparam int DEF_MAX_HEIGHT = 64;

   // Size register width and reset value
   localparam int SIZE_REG_WIDTH = 7;
   localparam logic [SIZE_REG_WIDTH-1:0] SIZE_RESET = 7'd50;
   localparam int MIN_SIZE = 3;

   // Rule counts for B3/S23
   localparam logic [3:0] BIRTH_COUNT = 4'd3;
   localparam logic [3:0] KEEP_COUNT  = 4'd2;

   // Configuration register indexes
   localparam int CSR_INDEX_WIDTH = 2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_HEIGHT = 2'd1;

   typedef enum logic [1:0] {
      KIND_WRITE   = 2'd0,
      KIND_READ    = 2'd1,
      KIND_CLEAR   = 2'd2,
      KIND_ADVANCE = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type   kind;
      logic [5:0] col;
      logic [5:0] row;
      logic       value;
   } req_type;

   typedef struct packed {
      logic cell_alive;
      logic bad_coord;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE      = 3'd0,
      ST_CELL      = 3'd1,
      ST_GEN_LAST  = 3'd2,
      ST_GEN_FIRST = 3'd3,
      ST_GEN_LOAD  = 3'd4,
      ST_GEN_ROW   = 3'd5,
      ST_RESP      = 3'd6
   } state_type;

endpackage

### hw/rtl/lats_row_mem.sv
// Row memory of the cell grid with per-row valid flags for reset and clear.
module lats_row_mem #(
   parameter int ROWS = 64,
   parameter int BITS = 64,
   parameter int AW   = 6
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            clr,
   input  logic            rd_en,
   input  logic [AW-1:0]   rd_addr,
   output logic [BITS-1:0] rd_data,
   input  logic            wr_en,
   input  logic [AW-1:0]   wr_addr,
   input  logic [BITS-1:0] wr_data
);

   logic [BITS-1:0] mem [ROWS];
   logic [ROWS-1:0] valid_ff;
   logic [BITS-1:0] rd_data_ff;

   // Write port and registered read; a row never written reads as all dead
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= valid_ff[rd_addr] ? mem[rd_addr] : '0;
      end
   end

   // Track written rows; drop all of them on reset or clear
   always_ff @(posedge clock) begin
      if (reset || clr) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/lats_row_unit.sv
// Next-generation logic for one row, with wraparound at the width in use.
module lats_row_unit #(
   parameter int MAX_WIDTH = 64,
   parameter int CIW       = 6,
   parameter int WSW       = 7
) (
   input  logic [MAX_WIDTH-1:0] above,
   input  logic [MAX_WIDTH-1:0] cur,
   input  logic [MAX_WIDTH-1:0] below,
   input  logic [WSW-1:0]       width,
   output logic [MAX_WIDTH-1:0] nxt
);

   logic [CIW-1:0] last_idx;
   logic           above_last;
   logic           cur_last;
   logic           below_last;

   // Pick the bits of the last column in use once, shared by column zero
   assign last_idx   = CIW'(width - WSW'(1));
   assign above_last = above[last_idx];
   assign cur_last   = cur[last_idx];
   assign below_last = below[last_idx];

   for (genvar c = 0; c < MAX_WIDTH; c++) begin : g_col
      localparam int LI = (c == 0) ? MAX_WIDTH - 1 : c - 1;
      localparam int RI = (c == MAX_WIDTH - 1) ? 0 : c + 1;

      logic       is_last;
      logic       a_l, a_r, c_l, c_r, b_l, b_r;
      logic [3:0] count;
      logic       now;

      assign is_last = (WSW'(c) == width - WSW'(1));

      // Wrap left neighbors at column zero, right neighbors at the last column
      assign a_l = (c == 0) ? above_last : above[LI];
      assign c_l = (c == 0) ? cur_last   : cur[LI];
      assign b_l = (c == 0) ? below_last : below[LI];
      assign a_r = is_last ? above[0] : above[RI];
      assign c_r = is_last ? cur[0]   : cur[RI];
      assign b_r = is_last ? below[0] : below[RI];

      assign count = 4'(a_l) + 4'(above[c]) + 4'(a_r)
                   + 4'(b_l) + 4'(below[c]) + 4'(b_r)
                   + 4'(c_l) + 4'(c_r);

      assign now = (count == lats_pkg::BIRTH_COUNT)
                || (cur[c] && (count == lats_pkg::KEEP_COUNT));

      // Columns outside the width in use hold their value
      assign nxt[c] = (WSW'(c) < width) ? now : cur[c];
   end

endmodule

### hw/rtl/life_automaton_torus_step.sv
// Top level of the toroidal B3/S23 life engine: sequencer, size registers, response stage.
// Each request beat writes a cell, reads a cell, clears the grid or advances one generation,
// and yields exactly one response beat. The grid lives in a row memory with one read and
// one write port, and the shared row unit computes one row per cycle as the sequencer walks
// the rows, carrying the old first and previous rows in registers. New requests are taken
// only when the sequencer is idle; a finished response sits in an output register so the next
// request can be accepted before it is taken. Per-row valid flags make reset and clear take
// effect at once, with no sweep of the memory. Sizes below 3 are used as 3 and sizes above the
// storage bounds are used as the bounds; configuration writes are accepted at any time but
// must only be issued while the block is idle.
module life_automaton_torus_step #(
   parameter int MAX_WIDTH  = lats_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = lats_pkg::DEF_MAX_HEIGHT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  lats_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output lats_pkg::rsp_type                   rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [lats_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [lats_pkg::SIZE_REG_WIDTH-1:0]  csr_data
);

   localparam int SRW  = lats_pkg::SIZE_REG_WIDTH;
   localparam int WCL  = $clog2(MAX_WIDTH + 1);
   localparam int HCL  = $clog2(MAX_HEIGHT + 1);
   localparam int WSW  = (WCL > SRW) ? WCL : SRW;
   localparam int HSW  = (HCL > SRW) ? HCL : SRW;
   localparam int CIW  = $clog2(MAX_WIDTH);
   localparam int RAW  = $clog2(MAX_HEIGHT);

   lats_pkg::state_type state_ff, state_in;

   logic [SRW-1:0]       width_ff;
   logic [SRW-1:0]       height_ff;
   logic [WSW-1:0]       w_ext, eff_w;
   logic [HSW-1:0]       h_ext, eff_h;

   lats_pkg::req_type    op_ff;
   lats_pkg::rsp_type    res_ff;
   logic                 rsp_valid_ff;
   lats_pkg::rsp_type    rsp_data_ff;

   logic [RAW-1:0]       row_ff;
   logic [MAX_WIDTH-1:0] first_ff;
   logic [MAX_WIDTH-1:0] prev_ff;
   logic [MAX_WIDTH-1:0] cur_ff;

   logic                 accept;
   logic                 bad_coord;
   logic                 cell_kind;
   logic                 slot_free;
   logic                 last_row;
   logic [HSW-1:0]       ahead_row;
   logic [RAW-1:0]       last_addr;
   logic [CIW-1:0]       col_idx;
   logic [MAX_WIDTH-1:0] below_row;
   logic [MAX_WIDTH-1:0] gen_row;
   logic [MAX_WIDTH-1:0] cell_row;

   logic                 mem_clr;
   logic                 mem_rd_en;
   logic [RAW-1:0]       mem_rd_addr;
   logic [MAX_WIDTH-1:0] mem_rd_data;
   logic                 mem_wr_en;
   logic [RAW-1:0]       mem_wr_addr;
   logic [MAX_WIDTH-1:0] mem_wr_data;

   // Clamp the size registers to the range in use
   assign w_ext = WSW'(width_ff);
   assign h_ext = HSW'(height_ff);
   assign eff_w = (w_ext < WSW'(lats_pkg::MIN_SIZE)) ? WSW'(lats_pkg::MIN_SIZE)
                : (w_ext > WSW'(MAX_WIDTH))          ? WSW'(MAX_WIDTH) : w_ext;
   assign eff_h = (h_ext < HSW'(lats_pkg::MIN_SIZE)) ? HSW'(lats_pkg::MIN_SIZE)
                : (h_ext > HSW'(MAX_HEIGHT))         ? HSW'(MAX_HEIGHT) : h_ext;

   // Configuration writes
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= lats_pkg::SIZE_RESET;
         height_ff <= lats_pkg::SIZE_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            lats_pkg::CSR_WIDTH:  width_ff  <= csr_data;
            lats_pkg::CSR_HEIGHT: height_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Decode the request beat
   assign accept    = req_valid && req_ready;
   assign cell_kind = (req_data.kind == lats_pkg::KIND_WRITE)
                   || (req_data.kind == lats_pkg::KIND_READ);
   assign bad_coord = (WSW'(req_data.col) >= eff_w) || (HSW'(req_data.row) >= eff_h);

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign last_row  = (HSW'(row_ff) == eff_h - HSW'(1));
   assign ahead_row = HSW'(row_ff) + HSW'(2);
   assign last_addr = RAW'(eff_h - HSW'(1));
   assign col_idx   = CIW'(op_ff.col);
   assign below_row = last_row ? first_ff : mem_rd_data;

   // Cell update for a write beat
   always_comb begin
      cell_row          = mem_rd_data;
      cell_row[col_idx] = op_ff.value;
   end

   lats_row_unit #(
      .MAX_WIDTH (MAX_WIDTH),
      .CIW       (CIW),
      .WSW       (WSW)
   ) u_row_unit (
      .above (prev_ff),
      .cur   (cur_ff),
      .below (below_row),
      .width (eff_w),
      .nxt   (gen_row)
   );

   lats_row_mem #(
      .ROWS (MAX_HEIGHT),
      .BITS (MAX_WIDTH),
      .AW   (RAW)
   ) u_row_mem (
      .clock   (clock),
      .reset   (reset),
      .clr     (mem_clr),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data)
   );

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         lats_pkg::ST_IDLE: begin
            if (req_valid) begin
               priority if (cell_kind && !bad_coord) state_in = lats_pkg::ST_CELL;
               else if (req_data.kind == lats_pkg::KIND_ADVANCE)
                  state_in = lats_pkg::ST_GEN_LAST;
               else state_in = lats_pkg::ST_RESP;
            end
         end
         lats_pkg::ST_CELL:      state_in = lats_pkg::ST_RESP;
         lats_pkg::ST_GEN_LAST:  state_in = lats_pkg::ST_GEN_FIRST;
         lats_pkg::ST_GEN_FIRST: state_in = lats_pkg::ST_GEN_LOAD;
         lats_pkg::ST_GEN_LOAD:  state_in = lats_pkg::ST_GEN_ROW;
         lats_pkg::ST_GEN_ROW: begin
            if (last_row) state_in = lats_pkg::ST_RESP;
         end
         lats_pkg::ST_RESP: begin
            if (slot_free) state_in = lats_pkg::ST_IDLE;
         end
         default: state_in = lats_pkg::ST_IDLE;
      endcase
   end

   // Outputs toward the handshake and the row memory
   always_comb begin
      req_ready   = 1'b0;
      mem_clr     = 1'b0;
      mem_rd_en   = 1'b0;
      mem_rd_addr = '0;
      mem_wr_en   = 1'b0;
      mem_wr_addr = row_ff;
      mem_wr_data = gen_row;
      unique case (state_ff)
         lats_pkg::ST_IDLE: begin
            req_ready   = 1'b1;
            mem_clr     = req_valid && (req_data.kind == lats_pkg::KIND_CLEAR);
            mem_rd_en   = req_valid && cell_kind && !bad_coord;
            mem_rd_addr = RAW'(req_data.row);
         end
         lats_pkg::ST_CELL: begin
            mem_wr_en   = (op_ff.kind == lats_pkg::KIND_WRITE);
            mem_wr_addr = RAW'(op_ff.row);
            mem_wr_data = cell_row;
         end
         lats_pkg::ST_GEN_LAST: begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = last_addr;
         end
         lats_pkg::ST_GEN_FIRST: begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = '0;
         end
         lats_pkg::ST_GEN_LOAD: begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = RAW'(1);
         end
         lats_pkg::ST_GEN_ROW: begin
            mem_wr_en   = 1'b1;
            mem_rd_en   = (ahead_row < eff_h);
            mem_rd_addr = RAW'(ahead_row);
         end
         lats_pkg::ST_RESP: ;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lats_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Datapath registers of the sequencer
   always_ff @(posedge clock) begin
      unique case (state_ff)
         lats_pkg::ST_IDLE: begin
            if (accept) begin
               op_ff            <= req_data;
               res_ff.cell_alive <= 1'b0;
               res_ff.bad_coord  <= cell_kind && bad_coord;
            end
         end
         lats_pkg::ST_CELL: begin
            res_ff.cell_alive <= (op_ff.kind == lats_pkg::KIND_READ) && mem_rd_data[col_idx];
         end
         lats_pkg::ST_GEN_FIRST: begin
            prev_ff <= mem_rd_data;
         end
         lats_pkg::ST_GEN_LOAD: begin
            first_ff <= mem_rd_data;
            cur_ff   <= mem_rd_data;
            row_ff   <= '0;
         end
         lats_pkg::ST_GEN_ROW: begin
            prev_ff <= cur_ff;
            cur_ff  <= below_row;
            row_ff  <= row_ff + RAW'(1);
         end
         default: ;
      endcase
   end

   // Response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if ((state_ff == lats_pkg::ST_RESP) && slot_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if ((state_ff == lats_pkg::ST_RESP) && slot_free) begin
         rsp_data_ff <= res_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Checks on the sequencer
   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == lats_pkg::ST_IDLE) |-> !mem_wr_en)
      else $error("row memory written while idle");

   a_row_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == lats_pkg::ST_GEN_ROW) |-> (HSW'(row_ff) < eff_h))
      else $error("generation row counter past height in use");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_ready)
      else $error("request accepted while previous item still in work");

   a_rsp_from_resp: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == lats_pkg::ST_RESP))
      else $error("response raised outside the response state");

endmodule

### sim/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for the toroidal life engine: seeded patterns, generations, grid reads.
module testbench;
   import lats_pkg::*;

   localparam int GRID_MAX_W       = DEF_MAX_WIDTH;
   localparam int GRID_MAX_H       = DEF_MAX_HEIGHT;
   localparam int RANDOM_ITEMS     = 1700;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int DRAIN_CYCLES     = 80;
   localparam int FIXED_PHASES     = 5;
   localparam int FULL_READ_CELLS  = 36;

   // Indexes past the two size registers; writes there must be ignored
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SPARE_2 = 2'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SPARE_3 = 2'd3;

   typedef enum int {
      READY_ALWAYS,
      READY_HALF,
      READY_SPARSE
   } ready_mode_type;

   logic                       clock     = 1'b0;
   logic                       reset     = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   req_type                    req_data  = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   rsp_type                    rsp_data;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [SIZE_REG_WIDTH-1:0]  csr_data  = '0;

   // Local copy of the engine state
   logic [SIZE_REG_WIDTH-1:0] width_reg  = SIZE_RESET;
   logic [SIZE_REG_WIDTH-1:0] height_reg = SIZE_RESET;
   logic [GRID_MAX_W-1:0]     life_grid [GRID_MAX_H];

   req_type pending_reqs [$];
   rsp_type expected_rsps [$];

   int unsigned error_count      = 0;
   int unsigned queued_items     = 0;
   int unsigned accepted_items   = 0;
   int unsigned checked_rsps     = 0;
   int unsigned generation_count = 0;
   int unsigned read_count       = 0;
   int unsigned size_settings    = 0;
   bit          hold_request     = 1'b0;

   logic [SIZE_REG_WIDTH-1:0] fixed_widths  [FIXED_PHASES] = '{7'd3, 7'd64, 7'd0, 7'd127, 7'd65};
   logic [SIZE_REG_WIDTH-1:0] fixed_heights [FIXED_PHASES] = '{7'd3, 7'd64, 7'd127, 7'd2, 7'd1};

   life_automaton_torus_step dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #4 clock = ~clock;

   // Clamp a size register to the range the engine actually uses
   function automatic int unsigned used_size(logic [SIZE_REG_WIDTH-1:0] reg_val,
                                             int unsigned limit);
      if (reg_val < MIN_SIZE) return MIN_SIZE;
      if (reg_val > limit) return limit;
      return reg_val;
   endfunction

   // Step every in-use cell from a snapshot of the old generation
   function automatic void advance_generation();
      logic [GRID_MAX_W-1:0] old_rows [GRID_MAX_H];
      int unsigned w, h, up, down, left, right, n;
      w = used_size(width_reg, GRID_MAX_W);
      h = used_size(height_reg, GRID_MAX_H);
      old_rows = life_grid;
      for (int unsigned r = 0; r < h; r++) begin
         up   = (r == 0) ? h - 1 : r - 1;
         down = (r == h - 1) ? 0 : r + 1;
         for (int unsigned c = 0; c < w; c++) begin
            left  = (c == 0) ? w - 1 : c - 1;
            right = (c == w - 1) ? 0 : c + 1;
            n = int'(old_rows[up][left]) + int'(old_rows[up][c]) + int'(old_rows[up][right])
              + int'(old_rows[r][left]) + int'(old_rows[r][right])
              + int'(old_rows[down][left]) + int'(old_rows[down][c])
              + int'(old_rows[down][right]);
            life_grid[r][c] = (n == BIRTH_COUNT) || (old_rows[r][c] && n == KEEP_COUNT);
         end
      end
   endfunction

   // Apply one request to the local grid and return the response it should give
   function automatic rsp_type predict_life_rsp(req_type item);
      rsp_type     res;
      int unsigned w, h;
      res = '0;
      w = used_size(width_reg, GRID_MAX_W);
      h = used_size(height_reg, GRID_MAX_H);
      case (item.kind)
         KIND_WRITE, KIND_READ: begin
            if (item.col >= w || item.row >= h) begin
               res.bad_coord = 1'b1;
            end else if (item.kind == KIND_WRITE) begin
               life_grid[item.row][item.col] = item.value;
            end else begin
               res.cell_alive = life_grid[item.row][item.col];
               read_count++;
            end
         end
         KIND_CLEAR: begin
            foreach (life_grid[i]) life_grid[i] = '0;
         end
         default: begin
            advance_generation();
            generation_count++;
         end
      endcase
      return res;
   endfunction

   function automatic req_type make_req(kind_type k, int unsigned c, int unsigned r, logic v);
      req_type item;
      item.kind  = k;
      item.col   = 6'(c);
      item.row   = 6'(r);
      item.value = v;
      return item;
   endfunction

   function automatic req_type noise_req();
      return make_req(kind_type'($urandom_range(0, 3)), $urandom_range(0, 63),
                      $urandom_range(0, 63), 1'($urandom_range(0, 1)));
   endfunction

   // Mostly legal sizes, with the clamped ends showing up often
   function automatic logic [SIZE_REG_WIDTH-1:0] pick_size_value();
      case ($urandom_range(0, 7))
         0:       return 7'($urandom_range(0, 2));
         1:       return 7'($urandom_range(65, 127));
         2:       return 7'd64;
         3:       return 7'd3;
         4:       return 7'($urandom_range(13, 64));
         default: return 7'($urandom_range(3, 12));
      endcase
   endfunction

   task automatic report_mismatch(string what);
      error_count++;
      $display("mismatch at %0t: %s", $time, what);
   endtask

   task automatic queue_req(req_type item);
      pending_reqs.push_back(item);
      queued_items++;
   endtask

   // Hold until no beat is pending, on offer or outstanding
   task automatic wait_for_idle();
      while (accepted_items != queued_items || expected_rsps.size() != 0)
         @(posedge clock);
   endtask

   // Valid stays up across back-to-back writes; the caller drops it afterwards
   task automatic write_size_reg(logic [CSR_INDEX_WIDTH-1:0] idx,
                                 logic [SIZE_REG_WIDTH-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_WIDTH) width_reg = val;
      else if (idx == CSR_HEIGHT) height_reg = val;
   endtask

   // Edge cases at the reset size of 50 by 50
   task automatic queue_directed_items();
      queue_req(make_req(KIND_WRITE, 0, 0, 1'b1));
      queue_req(make_req(KIND_WRITE, 49, 49, 1'b1));
      queue_req(make_req(KIND_READ, 0, 0, 1'b0));
      queue_req(make_req(KIND_READ, 49, 49, 1'b1));
      queue_req(make_req(KIND_READ, 48, 49, 1'b0));
      // coordinates just past the size in use and at the field maximum
      queue_req(make_req(KIND_WRITE, 50, 0, 1'b1));
      queue_req(make_req(KIND_WRITE, 0, 50, 1'b1));
      queue_req(make_req(KIND_READ, 63, 63, 1'b1));
      queue_req(make_req(KIND_READ, 50, 49, 1'b0));
      // clear with junk coordinates must not flag them
      queue_req(make_req(KIND_CLEAR, 63, 63, 1'b1));
      queue_req(make_req(KIND_READ, 0, 0, 1'b0));
      queue_req(make_req(KIND_READ, 49, 49, 1'b0));
      // blinker straddling the left/right seam
      queue_req(make_req(KIND_WRITE, 49, 0, 1'b1));
      queue_req(make_req(KIND_WRITE, 0, 0, 1'b1));
      queue_req(make_req(KIND_WRITE, 1, 0, 1'b1));
      queue_req(make_req(KIND_ADVANCE, 63, 63, 1'b1));
      queue_req(make_req(KIND_READ, 0, 49, 1'b0));
      queue_req(make_req(KIND_READ, 0, 0, 1'b0));
      queue_req(make_req(KIND_READ, 0, 1, 1'b0));
      queue_req(make_req(KIND_READ, 49, 0, 1'b0));
      queue_req(make_req(KIND_ADVANCE, 0, 0, 1'b0));
      queue_req(make_req(KIND_READ, 49, 0, 1'b0));
      queue_req(make_req(KIND_READ, 0, 49, 1'b0));
      queue_req(make_req(KIND_WRITE, 63, 63, 1'b0));
   endtask

   // Seed a patch, run a few generations, read around the patch (or every cell of a small grid), sprinkle noise
   task automatic queue_random_phase();
      int unsigned w, h, pw, ph, c0, r0;
      w = used_size(width_reg, GRID_MAX_W);
      h = used_size(height_reg, GRID_MAX_H);
      pw = (w <= 8) ? w : $urandom_range(3, 8);
      ph = (h <= 8) ? h : $urandom_range(3, 8);
      c0 = $urandom_range(0, w - 1);
      r0 = $urandom_range(0, h - 1);
      if ($urandom_range(0, 1) == 0) queue_req(make_req(KIND_CLEAR, $urandom_range(0, 63),
                                                        $urandom_range(0, 63), 1'b0));
      for (int unsigned i = 0; i < ph; i++)
         for (int unsigned j = 0; j < pw; j++)
            queue_req(make_req(KIND_WRITE, (c0 + j) % w, (r0 + i) % h,
                               $urandom_range(0, 99) < 45));
      repeat ($urandom_range(1, 4)) begin
         repeat ($urandom_range(1, 3))
            queue_req(make_req(KIND_ADVANCE, $urandom_range(0, 63), $urandom_range(0, 63),
                               1'($urandom_range(0, 1))));
         if (w * h <= FULL_READ_CELLS) begin
            for (int unsigned r = 0; r < h; r++)
               for (int unsigned c = 0; c < w; c++)
                  queue_req(make_req(KIND_READ, c, r, 1'($urandom_range(0, 1))));
         end else begin
            repeat (12)
               queue_req(make_req(KIND_READ, (c0 + w - 2 + $urandom_range(0, pw + 3)) % w,
                                  (r0 + h - 2 + $urandom_range(0, ph + 3)) % h,
                                  1'($urandom_range(0, 1))));
         end
         repeat ($urandom_range(0, 4)) queue_req(noise_req());
         if ($urandom_range(0, 2) == 0) begin
            if (w < GRID_MAX_W)
               queue_req(make_req(kind_type'($urandom_range(0, 1)), $urandom_range(w, 63),
                                  $urandom_range(0, 63), 1'($urandom_range(0, 1))));
            else if (h < GRID_MAX_H)
               queue_req(make_req(kind_type'($urandom_range(0, 1)), $urandom_range(0, 63),
                                  $urandom_range(h, 63), 1'($urandom_range(0, 1))));
         end
      end
   endtask

   // Request driver: bursts of beats with random gaps between them
   int unsigned burst_left = 1;
   int unsigned gap_left   = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         // predict each accepted beat
         if (req_valid && req_ready) begin
            expected_rsps.push_back(predict_life_rsp(req_data));
            accepted_items++;
         end
         // hold an offered beat until taken, else load the next one
         if (!req_valid || req_ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
               req_valid <= 1'b1;
               req_data  <= pending_reqs.pop_front();
               if (burst_left > 1) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(1, 16);
                  gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor and receiver stall pattern
   int unsigned    hold_left = 0;
   int unsigned    mode_left = 0;
   bit             hold_done = 1'b0;
   ready_mode_type ready_mode = READY_ALWAYS;
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         // compare each taken beat with the oldest prediction
         if (rsp_valid && rsp_ready) begin
            if (expected_rsps.size() == 0) begin
               report_mismatch($sformatf("response %b with nothing expected", rsp_data));
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_data.cell_alive !== want.cell_alive)
                  report_mismatch($sformatf("response %0d cell_alive %b, expected %b",
                                            checked_rsps, rsp_data.cell_alive, want.cell_alive));
               if (rsp_data.bad_coord !== want.bad_coord)
                  report_mismatch($sformatf("response %0d bad_coord %b, expected %b",
                                            checked_rsps, rsp_data.bad_coord, want.bad_coord));
            end
            checked_rsps++;
         end
         // one long hold-off so the engine backs up into its input
         if (hold_request && !hold_done) begin
            hold_done = 1'b1;
            hold_left = LONG_HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            if (mode_left == 0) begin
               ready_mode = ready_mode_type'($urandom_range(0, 2));
               mode_left  = $urandom_range(8, 64);
            end
            mode_left--;
            case (ready_mode)
               READY_ALWAYS: rsp_ready <= 1'b1;
               READY_HALF:   rsp_ready <= 1'($urandom_range(0, 1));
               default:      rsp_ready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   // Stimulus sequence and final verdict
   initial begin
      int unsigned phase;
      int unsigned item_goal;
      foreach (life_grid[i]) life_grid[i] = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      queue_directed_items();
      item_goal = queued_items + RANDOM_ITEMS;
      for (phase = 0; queued_items < item_goal; phase++) begin
         wait_for_idle();
         if (phase < FIXED_PHASES) begin
            write_size_reg(CSR_WIDTH, fixed_widths[phase]);
            write_size_reg(CSR_HEIGHT, fixed_heights[phase]);
            if (phase == 0) begin
               write_size_reg(CSR_SPARE_2, 7'h55);
               write_size_reg(CSR_SPARE_3, 7'h2a);
            end
         end else begin
            if ($urandom_range(0, 3) != 0) write_size_reg(CSR_WIDTH, pick_size_value());
            if ($urandom_range(0, 3) != 0) write_size_reg(CSR_HEIGHT, pick_size_value());
            if ($urandom_range(0, 7) == 0)
               write_size_reg($urandom_range(0, 1) ? CSR_SPARE_2 : CSR_SPARE_3, 7'($urandom));
         end
         csr_valid <= 1'b0;
         size_settings++;
         queue_random_phase();
         if (phase == 3) hold_request = 1'b1;
      end
      wait_for_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_rsps.size() != 0)
         report_mismatch($sformatf("%0d responses never arrived", expected_rsps.size()));
      $display("summary: %0d requests over %0d size settings, %0d generations, %0d cell reads",
               accepted_items, size_settings, generation_count, read_count);
      $display("summary: %0d responses compared, %0d mismatches", checked_rsps, error_count);
      if (error_count == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

   // Watchdog for a hung handshake
   initial begin
      #8_000_000;
      $display("timeout: %0d responses still outstanding", expected_rsps.size());
      $display("testbench: done, errors");
      $finish;
   end

endmodule

### sim.f
hw/rtl/lats_pkg.sv
hw/rtl/lats_row_mem.sv
hw/rtl/lats_row_unit.sv
hw/rtl/life_automaton_torus_step.sv
sim/testbench.sv
